@@ rtl/ardec_pkg.sv @@
// Package for the ADPCM resampling decoder.
// Holds the decoder constants, the step and index tables, and the command and
// status structs that pass between the controller and the datapath.
`default_nettype none

package ardec_pkg;

    localparam int unsigned RATE_W   = 20;
    localparam int unsigned MODE_W   = 1;
    localparam int unsigned VOLUME_W = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned LEVEL_W  = 20;
    localparam int unsigned PRED_W   = 12;
    localparam int unsigned INDEX_W  = 6;

    localparam logic [RATE_W-1:0] STEP_MODE0 = 20'd187500;
    localparam logic [RATE_W-1:0] STEP_MODE1 = 20'd750000;
    localparam logic [RATE_W-1:0] RATE_RESET = 20'd187500;
    localparam logic [VOLUME_W-1:0] VOLUME_RESET = 16'd256;
    localparam logic [8:0] HPF_COEF = 9'd459;
    localparam logic signed [13:0] PRED_MAX = 14'sd2047;
    localparam logic signed [13:0] PRED_MIN = -14'sd2047;
    localparam logic signed [7:0] INDEX_MAX = 8'sd48;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME = 2'd2;

    typedef struct packed {
        logic capture;
        logic phase;
        logic mult;
        logic filt;
        logic vol;
        logic load_out;
    } ardec_cmd_t;

    typedef struct packed {
        logic skip;
    } ardec_status_t;

    // Standard OKI step table; indexes past the end read as the last entry.
    function automatic logic [10:0] step_tab(input logic [INDEX_W-1:0] idx);
        logic [10:0] s;
        case (idx)
            6'd0:  s = 11'd16;
            6'd1:  s = 11'd17;
            6'd2:  s = 11'd19;
            6'd3:  s = 11'd21;
            6'd4:  s = 11'd23;
            6'd5:  s = 11'd25;
            6'd6:  s = 11'd28;
            6'd7:  s = 11'd31;
            6'd8:  s = 11'd34;
            6'd9:  s = 11'd37;
            6'd10: s = 11'd41;
            6'd11: s = 11'd45;
            6'd12: s = 11'd50;
            6'd13: s = 11'd55;
            6'd14: s = 11'd60;
            6'd15: s = 11'd66;
            6'd16: s = 11'd73;
            6'd17: s = 11'd80;
            6'd18: s = 11'd88;
            6'd19: s = 11'd97;
            6'd20: s = 11'd107;
            6'd21: s = 11'd118;
            6'd22: s = 11'd130;
            6'd23: s = 11'd143;
            6'd24: s = 11'd157;
            6'd25: s = 11'd173;
            6'd26: s = 11'd190;
            6'd27: s = 11'd209;
            6'd28: s = 11'd230;
            6'd29: s = 11'd253;
            6'd30: s = 11'd279;
            6'd31: s = 11'd307;
            6'd32: s = 11'd337;
            6'd33: s = 11'd371;
            6'd34: s = 11'd408;
            6'd35: s = 11'd449;
            6'd36: s = 11'd494;
            6'd37: s = 11'd544;
            6'd38: s = 11'd598;
            6'd39: s = 11'd658;
            6'd40: s = 11'd724;
            6'd41: s = 11'd796;
            6'd42: s = 11'd876;
            6'd43: s = 11'd963;
            6'd44: s = 11'd1060;
            6'd45: s = 11'd1166;
            6'd46: s = 11'd1282;
            6'd47: s = 11'd1411;
            default: s = 11'd1552;
        endcase
        return s;
    endfunction

    function automatic logic signed [4:0] index_adj(input logic [2:0] mag);
        logic signed [4:0] a;
        case (mag)
            3'd4:    a = 5'sd2;
            3'd5:    a = 5'sd4;
            3'd6:    a = 5'sd6;
            3'd7:    a = 5'sd8;
            default: a = -5'sd1;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

@@ rtl/adpcm_resampling_decoder_top.sv @@
// Top level of the ADPCM resampling decoder.
// Joins ardec_ctrl and ardec_datapath; uses ardec_pkg.
//
// Usage: one input transfer per output tick (cmd 0) or key-on restart
// (cmd 1), with the source's offered byte and the halt flag. Each input
// transfer gives exactly one output transfer carrying sample, sample_valid
// and byte_taken. A restart, a halted tick and a starved tick give
// sample 0 with sample_valid and byte_taken low.
// Configuration: cfg_index 0 rate, 1 output mode, 2 volume; cfg_ready is
// always high. Write only while no item is in flight.
// Sequence: an item that produces a sample runs capture, phase and decode,
// filter multiply, filter update, volume multiply and output load;
// out_valid rises and in_ready returns as the output load completes. Items
// that give no sample go from phase straight to output load. Both output
// modes run the one shared sequence of filter steps.
// An output register holds the result, so the next item is taken while it
// waits; if the receiver stalls, the following result waits in the
// controller until the register frees. Reset clears all decoder state and
// loads the configuration defaults.
`default_nettype none

module adpcm_resampling_decoder_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [ardec_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ardec_pkg::RATE_W-1:0]        cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                cmd,
    input  wire logic [7:0]                          adpcm_byte,
    input  wire logic                                byte_valid,
    input  wire logic                                halted,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [ardec_pkg::SAMPLE_W-1:0]    sample,
    output logic                                     sample_valid,
    output logic                                     byte_taken
);

    ardec_pkg::ardec_cmd_t    ctrl_cmd;
    ardec_pkg::ardec_status_t dp_status;

    assign cfg_ready = 1'b1;

    ardec_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (dp_status),
        .cmd       (ctrl_cmd)
    );

    ardec_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd_in       (cmd),
        .adpcm_byte   (adpcm_byte),
        .byte_valid   (byte_valid),
        .halted       (halted),
        .cmd          (ctrl_cmd),
        .status       (dp_status),
        .sample       (sample),
        .sample_valid (sample_valid),
        .byte_taken   (byte_taken)
    );

endmodule

`default_nettype wire

@@ rtl/ardec_ctrl.sv @@
// Controller of the ADPCM resampling decoder.
// Sequences one item through the datapath; uses ardec_pkg command/status types.
`default_nettype none

module ardec_ctrl (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    input  wire ardec_pkg::ardec_status_t status,
    output ardec_pkg::ardec_cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PHASE,
        S_MULT,
        S_FILT,
        S_VOL,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_PHASE;
                end
            end
            S_PHASE:
            begin
                cmd.phase  = 1'b1;
                state_next = status.skip ? S_OUT : S_MULT;
            end
            S_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = S_FILT;
            end
            S_FILT:
            begin
                cmd.filt   = 1'b1;
                state_next = S_VOL;
            end
            S_VOL:
            begin
                cmd.vol    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // Hold the finished result until the output register is free.
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ rtl/ardec_datapath.sv @@
// Datapath of the ADPCM resampling decoder: configuration registers, phase
// accumulator, nibble decoder, high-pass filters and output register.
// Depends on ardec_pkg for constants, tables and command/status types.
`default_nettype none

module ardec_datapath (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_valid,
    input  wire logic [ardec_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [ardec_pkg::RATE_W-1:0]          cfg_data,
    input  wire logic                                  cmd_in,
    input  wire logic [7:0]                            adpcm_byte,
    input  wire logic                                  byte_valid,
    input  wire logic                                  halted,
    input  wire ardec_pkg::ardec_cmd_t                 cmd,
    output ardec_pkg::ardec_status_t                   status,
    output logic signed [ardec_pkg::SAMPLE_W-1:0]      sample,
    output logic                                       sample_valid,
    output logic                                       byte_taken
);

    localparam int unsigned SW = ardec_pkg::SAMPLE_W;
    localparam int unsigned LW = ardec_pkg::LEVEL_W;
    localparam int unsigned RW = ardec_pkg::RATE_W;
    localparam logic [8:0] HPF_COEF_EXT = ardec_pkg::HPF_COEF;

    // Configuration.
    logic [RW-1:0]                       rate_reg;
    logic                                mode_reg;
    logic [ardec_pkg::VOLUME_W-1:0]      volume_reg;

    // Captured item.
    logic                                cmdin_reg;
    logic [7:0]                          byte_reg;
    logic                                bvalid_reg;
    logic                                halted_reg;

    // Decoder and filter state.
    logic [ardec_pkg::INDEX_W-1:0]       step_index_reg;
    logic signed [ardec_pkg::PRED_W-1:0] predictor_reg;
    logic [3:0]                          held_reg;
    logic                                pending_reg;
    logic [RW-1:0]                       phase_reg;
    logic signed [LW-1:0]                level_reg;
    logic signed [LW-1:0]                prev_level_reg;
    logic signed [SW-1:0]                filter_reg;
    logic signed [SW-1:0]                stage1_reg;
    logic signed [SW-1:0]                prev_stage1_reg;

    logic                                produce_reg;
    logic                                taken_reg;
    logic [SW-1:0]                       mul_reg;
    logic [SW-1:0]                       vol_prod_reg;

    logic signed [SW-1:0]                sample_reg;
    logic                                sample_valid_reg;
    logic                                byte_taken_reg;

    // Phase arithmetic.
    logic [RW-1:0]                       step_val;
    logic [RW-1:0]                       rate_eff;
    logic signed [RW:0]                  phase_diff;
    logic [RW:0]                         phase_wrap;
    logic                                due;
    logic                                starved;

    // Nibble decode.
    logic [3:0]                          nib;
    logic [10:0]                         step_s;
    logic [11:0]                         delta;
    logic signed [13:0]                  pred_sum;
    logic signed [ardec_pkg::PRED_W-1:0] pred_new;
    logic signed [4:0]                   adj;
    logic signed [7:0]                   idx_sum;
    logic [ardec_pkg::INDEX_W-1:0]       idx_new;

    // Filters.
    logic signed [SW-1:0]                level_diff;
    logic signed [SW-1:0]                t0;
    logic signed [SW-1:0]                s1;
    logic signed [SW-1:0]                f1;
    logic [SW+8:0]                       coef_prod;
    logic [SW+15:0]                      vol_prod;
    logic signed [SW-1:0]                result;

    assign step_val   = mode_reg ? ardec_pkg::STEP_MODE1 : ardec_pkg::STEP_MODE0;
    assign rate_eff   = (rate_reg > step_val) ? step_val : rate_reg;
    assign phase_diff = $signed({1'b0, phase_reg}) - $signed({1'b0, rate_eff});
    assign phase_wrap = phase_diff + {1'b0, step_val};
    assign due        = phase_diff[RW];
    assign starved    = due && !pending_reg && !bvalid_reg;

    assign status.skip = cmdin_reg || halted_reg || starved;

    always_comb
    begin
        nib    = pending_reg ? held_reg : byte_reg[3:0];
        step_s = ardec_pkg::step_tab(step_index_reg);
        delta  = {4'd0, step_s[10:3]};
        if (nib[2])
        begin
            delta = delta + {1'b0, step_s};
        end
        if (nib[1])
        begin
            delta = delta + {2'b00, step_s[10:1]};
        end
        if (nib[0])
        begin
            delta = delta + {3'b000, step_s[10:2]};
        end
        if (nib[3])
        begin
            pred_sum = $signed({{2{predictor_reg[11]}}, predictor_reg}) - $signed({2'b00, delta});
        end
        else
        begin
            pred_sum = $signed({{2{predictor_reg[11]}}, predictor_reg}) + $signed({2'b00, delta});
        end
        if (pred_sum > ardec_pkg::PRED_MAX)
        begin
            pred_new = 12'(ardec_pkg::PRED_MAX);
        end
        else if (pred_sum < ardec_pkg::PRED_MIN)
        begin
            pred_new = 12'(ardec_pkg::PRED_MIN);
        end
        else
        begin
            pred_new = pred_sum[11:0];
        end
        adj     = ardec_pkg::index_adj(nib[2:0]);
        idx_sum = $signed({2'b00, step_index_reg}) + $signed({{3{adj[4]}}, adj});
        if (idx_sum > ardec_pkg::INDEX_MAX)
        begin
            idx_new = 6'(ardec_pkg::INDEX_MAX);
        end
        else if (idx_sum < 0)
        begin
            idx_new = '0;
        end
        else
        begin
            idx_new = idx_sum[5:0];
        end
    end

    always_comb
    begin
        level_diff = ($signed({{(SW-LW){level_reg[LW-1]}}, level_reg})
                    - $signed({{(SW-LW){prev_level_reg[LW-1]}}, prev_level_reg})) <<< 9;
        t0 = level_diff + $signed(mul_reg);
        s1 = level_diff + stage1_reg - (stage1_reg >>> 5) - (stage1_reg >>> 10);
        f1 = stage1_reg - prev_stage1_reg + filter_reg
             - (filter_reg >>> 8) - (filter_reg >>> 9) - (filter_reg >>> 12);
        coef_prod = {9'd0, filter_reg} * {32'd0, HPF_COEF_EXT};
        vol_prod  = {16'd0, filter_reg} * {32'd0, volume_reg};
        if (!produce_reg)
        begin
            result = '0;
        end
        else if (mode_reg)
        begin
            result = filter_reg >>> 9;
        end
        else
        begin
            result = $signed(vol_prod_reg) >>> 8;
        end
    end

    // Configuration writes; an index past the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg   <= ardec_pkg::RATE_RESET;
            mode_reg   <= 1'b0;
            volume_reg <= ardec_pkg::VOLUME_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ardec_pkg::CFG_RATE:   rate_reg   <= cfg_data;
                ardec_pkg::CFG_MODE:   mode_reg   <= cfg_data[0];
                ardec_pkg::CFG_VOLUME: volume_reg <= cfg_data[ardec_pkg::VOLUME_W-1:0];
                default:               ;
            endcase
        end
    end

    // Captured item fields and product registers carry payload only.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmdin_reg  <= cmd_in;
            byte_reg   <= adpcm_byte;
            bvalid_reg <= byte_valid;
            halted_reg <= halted;
        end
        if (cmd.mult)
        begin
            mul_reg <= coef_prod[SW-1:0];
        end
        if (cmd.vol)
        begin
            vol_prod_reg <= vol_prod[SW-1:0];
        end
        if (cmd.load_out)
        begin
            sample_reg       <= result;
            sample_valid_reg <= produce_reg;
            byte_taken_reg   <= taken_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_index_reg  <= '0;
            predictor_reg   <= '0;
            held_reg        <= '0;
            pending_reg     <= 1'b0;
            phase_reg       <= '0;
            level_reg       <= '0;
            prev_level_reg  <= '0;
            filter_reg      <= '0;
            stage1_reg      <= '0;
            prev_stage1_reg <= '0;
            produce_reg     <= 1'b0;
            taken_reg       <= 1'b0;
        end
        else
        begin
            if (cmd.phase)
            begin
                produce_reg <= !status.skip;
                taken_reg   <= 1'b0;
                if (cmdin_reg)
                begin
                    // Key-on restart leaves the phase accumulator alone.
                    step_index_reg  <= '0;
                    predictor_reg   <= '0;
                    held_reg        <= '0;
                    pending_reg     <= 1'b0;
                    level_reg       <= '0;
                    prev_level_reg  <= '0;
                    filter_reg      <= '0;
                    stage1_reg      <= '0;
                    prev_stage1_reg <= '0;
                end
                else if (!halted_reg)
                begin
                    if (starved)
                    begin
                        phase_reg <= '0;
                    end
                    else if (due)
                    begin
                        phase_reg      <= phase_wrap[RW-1:0];
                        predictor_reg  <= pred_new;
                        step_index_reg <= idx_new;
                        level_reg      <= {pred_new[11:2], 2'b00, 8'd0};
                        if (pending_reg)
                        begin
                            pending_reg <= 1'b0;
                        end
                        else
                        begin
                            held_reg    <= byte_reg[7:4];
                            pending_reg <= 1'b1;
                            taken_reg   <= 1'b1;
                        end
                    end
                    else
                    begin
                        phase_reg <= phase_diff[RW-1:0];
                    end
                end
            end
            if (cmd.mult && mode_reg)
            begin
                stage1_reg <= s1;
            end
            if (cmd.filt)
            begin
                prev_level_reg <= level_reg;
                if (mode_reg)
                begin
                    filter_reg      <= f1;
                    prev_stage1_reg <= stage1_reg;
                end
                else
                begin
                    filter_reg <= t0 >>> 9;
                end
            end
        end
    end

    assign sample       = sample_reg;
    assign sample_valid = sample_valid_reg;
    assign byte_taken   = byte_taken_reg;

endmodule

`default_nettype wire
